// ===== design/mmnb_pkg.sv =====
// Package for the frame min-max normalizer: field widths, start values,
// command and state codes, and the divider handshake types.
// No dependencies.
`default_nettype none
package mmnb_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int EXT_W      = 17;
   localparam int INDEX_W    = 12;
   localparam int PIXEL_W    = 8;
   localparam int NUM_W      = 24;
   localparam int QUO_STEPS  = 8;
   localparam int STEP_W     = $clog2(QUO_STEPS);

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 1;

   localparam logic signed [EXT_W-1:0] MIN_START = 17'sd65535;
   localparam logic signed [EXT_W-1:0] MAX_START = -17'sd65535;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [NUM_W-1:0]      num;
      logic [SAMPLE_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [PIXEL_W-1:0]    quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== design/mmnb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module mmnb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/mmnb_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients below 256.
// Depends on mmnb_pkg.
`default_nettype none
module mmnb_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mmnb_pkg::div_req_type req,
   output mmnb_pkg::div_rsp_type     rsp
);
   import mmnb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [PIXEL_W-1:0]   low_ff, low_in;
   logic [SAMPLE_W-1:0]  den_ff, den_in;
   logic [SAMPLE_W:0]    trial;
   logic                 qbit;

   always_comb begin
      trial   = {rem_ff, low_ff[PIXEL_W-1]};
      qbit    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = req.num[NUM_W-1:PIXEL_W];
         low_in  = req.num[PIXEL_W-1:0];
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in  = qbit ? SAMPLE_W'(trial - {1'b0, den_ff}) : trial[SAMPLE_W-1:0];
         low_in  = {low_ff[PIXEL_W-2:0], qbit};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign rsp = '{done: done_ff, quotient: low_ff};

endmodule
`default_nettype wire

// ===== design/minmax_normalize_to_byte.sv =====
// Top level of the frame min-max normalizer: sample RAM, running extremes,
// read sequencer and output register. Depends on mmnb_pkg, mmnb_ram, mmnb_div.
//
// A load item (req_tuser[0] = 0) stores its sample at the next frame position
// and updates the running minimum and maximum; req_tuser[1] restarts the
// frame first, and a load into a full frame is dropped. A read item
// (req_tuser[0] = 1) returns 255*(x-min)/(max-min) of the indexed sample on
// rsp_tdata, or its low byte when min = max, or rsp_tuser = 1 with pixel 0
// when the index is not below the loaded count. One item is worked at a
// time: a read goes through RAM read, divider start, 8 divider steps,
// divider done and hand-off to the output register, skipping the divider for
// a flat frame and all but the hand-off when out of range, and the hand-off
// waits while the output register holds an unaccepted result. A finished
// result waits in the output register while the next item is taken.
`default_nettype none
module minmax_normalize_to_byte #(
   parameter int FRAME_DEPTH = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] sample, [27:16] read_index, [31:28] zero
   input  wire logic [mmnb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] cmd, [1] first_of_frame
   input  wire logic [mmnb_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] pixel
   output logic      [mmnb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] out_of_range
   output logic      [mmnb_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import mmnb_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FRAME_DEPTH);

   state_type                state_ff, state_in;
   logic signed [EXT_W-1:0]  min_ff, min_in;
   logic signed [EXT_W-1:0]  max_ff, max_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PIXEL_W-1:0]       pix_ff, pix_in;
   logic                     oor_ff, oor_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]       rsp_pix_ff, rsp_pix_in;
   logic                     rsp_oor_ff, rsp_oor_in;

   logic                     req_accept;
   logic                     cmd;
   logic                     first_of_frame;
   logic signed [SAMPLE_W-1:0] sample;
   logic [INDEX_W-1:0]       read_index;
   logic [CMP_W-1:0]         index_ext;
   logic                     index_oor;
   logic [CNT_W-1:0]         base_count;
   logic signed [EXT_W-1:0]  base_min;
   logic signed [EXT_W-1:0]  base_max;
   logic signed [EXT_W-1:0]  sample_ext;
   logic                     load_ok;
   logic                     out_free;
   logic                     flat;

   logic                     ram_we;
   logic                     ram_re;
   logic [SAMPLE_W-1:0]      ram_rdata;
   logic signed [EXT_W-1:0]  x_ext;
   logic [EXT_W-1:0]         diff;
   logic [EXT_W-1:0]         span;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign cmd            = req_tuser[0];
   assign first_of_frame = req_tuser[1];
   assign sample         = req_tdata[SAMPLE_W-1:0];
   assign read_index     = req_tdata[SAMPLE_W +: INDEX_W];
   assign req_accept     = req_tvalid && req_tready;

   assign index_ext  = CMP_W'(read_index);
   assign index_oor  = index_ext >= CMP_W'(count_ff);
   assign base_count = first_of_frame ? '0 : count_ff;
   assign base_min   = first_of_frame ? MIN_START : min_ff;
   assign base_max   = first_of_frame ? MAX_START : max_ff;
   assign sample_ext = EXT_W'(sample);
   assign load_ok    = base_count != DEPTH_CNT;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign flat       = min_ff == max_ff;

   assign x_ext = EXT_W'(signed'(ram_rdata));
   assign diff  = x_ext - min_ff;
   assign span  = max_ff - min_ff;

   mmnb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (base_count[ADDR_W-1:0]),
      .wr_data (sample),
      .rd_en   (ram_re),
      .rd_addr (index_ext[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   mmnb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && cmd == CMD_READ) begin
               state_in = index_oor ? ST_EMIT : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = flat ? ST_EMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = {diff[SAMPLE_W-1:0], {PIXEL_W{1'b0}}} - NUM_W'(diff[SAMPLE_W-1:0]);
      div_req.den   = span[SAMPLE_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ram_we     = req_accept && cmd == CMD_LOAD && load_ok;
            ram_re     = req_accept && cmd == CMD_READ && !index_oor;
         end
         ST_FETCH: begin
            div_req.start = !flat;
         end
         ST_DIVIDE, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      pix_in       = pix_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (ram_we) begin
         count_in = base_count + CNT_W'(1);
         min_in   = (sample_ext < base_min) ? sample_ext : base_min;
         max_in   = (sample_ext > base_max) ? sample_ext : base_max;
      end
      if (state_ff == ST_IDLE && req_accept && cmd == CMD_READ) begin
         pix_in = '0;
         oor_in = index_oor;
      end
      if (state_ff == ST_FETCH) begin
         pix_in = ram_rdata[PIXEL_W-1:0];
      end
      if (state_ff == ST_DIVIDE && div_rsp.done) begin
         pix_in = div_rsp.quotient;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = pix_ff;
         rsp_oor_in   = oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_START;
         max_ff       <= MAX_START;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff     <= pix_in;
      oor_ff     <= oor_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pix_ff;
   assign rsp_tuser[0] = rsp_oor_ff;

endmodule
`default_nettype wire

// ===== design/mmnb_checker.sv =====
// Port-level checks for the frame min-max normalizer, bound to the top level.
// Depends on mmnb_pkg and minmax_normalize_to_byte.
`default_nettype none
module mmnb_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [mmnb_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mmnb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [mmnb_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mmnb_pkg::*;

   logic req_read;
   logic req_load;

   assign req_read = req_tvalid && req_tready && req_tuser[0] == CMD_READ;
   assign req_load = req_tvalid && req_tready && req_tuser[0] == CMD_LOAD;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed or dropped");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("out-of-range item with nonzero pixel");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_read |=> !req_tready)
      else $error("item taken while a read is in flight");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_load |=> !$rose(rsp_tvalid))
      else $error("item produced by a load");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind minmax_normalize_to_byte mmnb_checker u_mmnb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
